// ----- rtl/dual_priority_drop_oldest_tx_queue_assert.svh -----
// Assertion macros for the dual priority transmit queue.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef DUAL_PRIORITY_DROP_OLDEST_TX_QUEUE_ASSERT_SVH
`define DUAL_PRIORITY_DROP_OLDEST_TX_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS

// Antecedent and consequent in the same cycle.
`define DPQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("dpq check failed");

// Consequent in the cycle after the antecedent.
`define DPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dpq check failed");

`else

`define DPQ_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define DPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/dpq_pkg.sv -----
// Shared types and constants for the dual priority transmit queue.
// No dependencies; used by the event counter bank and the queue top level.
package dpq_pkg;

	localparam int AUDIO_DEPTH_DEF   = 16;
	localparam int CONTROL_DEPTH_DEF = 4;

	localparam logic [15:0] KEEPALIVE_RESET = 16'd200;
	localparam logic [7:0]  STATUS_RESET    = 8'd0;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;
	localparam logic [CFG_INDEX_W-1:0] CFG_KEEPALIVE_PERIOD = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_STATUS_TYPE_CODE = 2'd1;

	// op codes
	localparam logic [2:0] OP_ENQ_AUDIO = 3'd0;
	localparam logic [2:0] OP_ENQ_CTRL  = 3'd1;
	localparam logic [2:0] OP_TX_START  = 3'd2;
	localparam logic [2:0] OP_TX_DONE   = 3'd3;
	localparam logic [2:0] OP_READ_CNT  = 3'd4;

	// sent / latched kind
	localparam logic [1:0] KIND_IDLE  = 2'd0;
	localparam logic [1:0] KIND_AUDIO = 2'd1;
	localparam logic [1:0] KIND_CTRL  = 2'd2;

	// event counter selects
	localparam int NUM_COUNTERS = 9;
	localparam int CNT_SEL_W    = 4;
	localparam logic [CNT_SEL_W-1:0] CNT_AUDIO_OVER  = 4'd0;
	localparam logic [CNT_SEL_W-1:0] CNT_CTRL_OVER   = 4'd1;
	localparam logic [CNT_SEL_W-1:0] CNT_STATUS_ENQ  = 4'd2;
	localparam logic [CNT_SEL_W-1:0] CNT_STATUS_DROP = 4'd3;
	localparam logic [CNT_SEL_W-1:0] CNT_TX_AUDIO    = 4'd4;
	localparam logic [CNT_SEL_W-1:0] CNT_TX_CTRL     = 4'd5;
	localparam logic [CNT_SEL_W-1:0] CNT_TX_IDLE     = 4'd6;
	localparam logic [CNT_SEL_W-1:0] CNT_TX_FAIL     = 4'd7;
	localparam logic [CNT_SEL_W-1:0] CNT_STATUS_TX   = 4'd8;

	typedef struct packed {
		logic [2:0]           op;
		logic [31:0]          entry_tag;
		logic [7:0]           entry_type;
		logic                 transfer_ok;
		logic [CNT_SEL_W-1:0] counter_select;
	} req_t;

	typedef struct packed {
		logic [1:0]  sent_kind;
		logic [31:0] sent_tag;
		logic [7:0]  sent_type;
		logic        dropped_oldest;
		logic        committed;
		logic        keepalive_due;
		logic [3:0]  audio_count;
		logic [1:0]  control_count;
		logic [31:0] counter_value;
	} rsp_t;

	// one ring slot
	typedef struct packed {
		logic [7:0]  entry_type;
		logic [31:0] entry_tag;
	} slot_t;

	// increment strobes into the event counter bank
	typedef struct packed {
		logic audio_over;
		logic ctrl_over;
		logic status_enq;
		logic status_lost;
		logic audio_sent;
		logic tx_ctrl;
		logic tx_idle;
		logic tx_fail;
		logic status_sent;
	} cnt_inc_t;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

endpackage

// ----- rtl/dpq_ring_ram.sv -----
// Ring storage: single write port, single read port, registered read data.
// Uses no package items; instantiated by the queue top level.
module dpq_ring_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 40
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/dpq_event_counters.sv -----
// Bank of nine wrapping 32-bit event counters with a select read.
// Depends on dpq_pkg for counter indexes and the increment struct.
module dpq_event_counters (
	input  logic                           clk,
	input  logic                           arst_n,
	input  dpq_pkg::cnt_inc_t              inc,
	input  logic [dpq_pkg::CNT_SEL_W-1:0]  sel,
	output logic [31:0]                    value
);

	logic [31:0]                     cnt_q [dpq_pkg::NUM_COUNTERS];
	logic [dpq_pkg::NUM_COUNTERS-1:0] inc_vec;

	always_comb begin
		inc_vec = '0;
		inc_vec[dpq_pkg::CNT_AUDIO_OVER]  = inc.audio_over;
		inc_vec[dpq_pkg::CNT_CTRL_OVER]   = inc.ctrl_over;
		inc_vec[dpq_pkg::CNT_STATUS_ENQ]  = inc.status_enq;
		inc_vec[dpq_pkg::CNT_STATUS_DROP] = inc.status_lost;
		inc_vec[dpq_pkg::CNT_TX_AUDIO]    = inc.audio_sent;
		inc_vec[dpq_pkg::CNT_TX_CTRL]     = inc.tx_ctrl;
		inc_vec[dpq_pkg::CNT_TX_IDLE]     = inc.tx_idle;
		inc_vec[dpq_pkg::CNT_TX_FAIL]     = inc.tx_fail;
		inc_vec[dpq_pkg::CNT_STATUS_TX]   = inc.status_sent;
	end

	for (genvar i = 0; i < dpq_pkg::NUM_COUNTERS; i++) begin : g_cnt
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cnt_q[i] <= '0;
			end else if (inc_vec[i]) begin
				cnt_q[i] <= cnt_q[i] + 32'd1;
			end
		end
	end

	always_comb begin
		if (sel < dpq_pkg::CNT_SEL_W'(dpq_pkg::NUM_COUNTERS)) begin
			value = cnt_q[sel];
		end else begin
			value = '0;
		end
	end

endmodule

// ----- rtl/dual_priority_drop_oldest_tx_queue.sv -----
// Dual ring transmit queue top level: control FSM, pointers, latch, output register.
// Depends on dpq_pkg, dpq_ring_ram, dpq_event_counters and the assertion header.
//
// Usage:
//   req channel (req_valid / req_stall / req) carries one operation per
//   transaction: enqueue audio, enqueue control, transfer start, transfer done
//   or counter read. rsp channel (rsp_valid / rsp_stall / rsp) returns exactly
//   one result per request, in order.
//   Each transaction first reads both ring heads synchronously at the accepting
//   edge, then in the execute state updates pointers, counters and writes the
//   ring memory. The result is registered when the execute state ends; a new
//   request is taken only after the last one has left the execute state.
//   The result sits in an output register; a new request is taken while it
//   waits. If the receiver stalls, the following transaction holds in its
//   execute cycle until the output register frees up, and req_stall stays high.
//   Reset clears pointers, the transfer latch, the keepalive count and all event
//   counters, and loads keepalive_period = 200, status_type_code = 0. Ring
//   contents are not cleared; no slot's data is used before it was written.
//   cfg_we writes register cfg_index (0 keepalive period, 1 status type code)
//   and should only be used while the queue is idle.
`include "dual_priority_drop_oldest_tx_queue_assert.svh"

module dual_priority_drop_oldest_tx_queue #(
	parameter int AUDIO_DEPTH   = dpq_pkg::AUDIO_DEPTH_DEF,
	parameter int CONTROL_DEPTH = dpq_pkg::CONTROL_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_stall,
	input  dpq_pkg::req_t                    req,
	output logic                             rsp_valid,
	input  logic                             rsp_stall,
	output dpq_pkg::rsp_t                    rsp,
	input  logic                             cfg_we,
	input  logic [dpq_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [dpq_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int AW     = $clog2(AUDIO_DEPTH);
	localparam int CW     = $clog2(CONTROL_DEPTH);
	localparam int SLOT_W = (AW > CW) ? AW : CW;
	localparam logic [AW-1:0] A_LAST = AW'(AUDIO_DEPTH - 1);
	localparam logic [CW-1:0] C_LAST = CW'(CONTROL_DEPTH - 1);

	dpq_pkg::state_t state_q, state_d;
	logic            req_fire;
	logic            ex_fire;

	dpq_pkg::req_t   req_s1;
	dpq_pkg::rsp_t   rsp_q, rsp_d;
	logic            rsp_valid_q;

	logic [15:0]     ka_period_q;
	logic [7:0]      status_code_q;
	logic [15:0]     ka_cnt_q, ka_cnt_n;
	logic [16:0]     ka_sum;

	logic [AW-1:0]   awp_q, arp_q, awp_n, arp_n, a_wp_inc, a_rp_inc;
	logic [CW-1:0]   cwp_q, crp_q, cwp_n, crp_n, c_wp_inc, c_rp_inc;
	logic            a_full, c_full;

	logic [1:0]        inflight_kind_q, inflight_kind_n;
	logic [SLOT_W-1:0] inflight_slot_q, inflight_slot_n;
	logic [7:0]        inflight_type_q, inflight_type_n;

	dpq_pkg::slot_t  a_rd, c_rd, wr_slot;
	logic            a_we, c_we;
	dpq_pkg::cnt_inc_t inc;
	logic [31:0]     cnt_value;

	// ---------------- handshake / FSM ----------------
	assign req_fire  = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dpq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_stall = 1'b1;
		ex_fire   = 1'b0;
		unique case (state_q)
			dpq_pkg::ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					state_d = dpq_pkg::ST_EXEC;
				end
			end
			dpq_pkg::ST_EXEC: begin
				// wait here until the output register is free
				if (!rsp_valid_q || !rsp_stall) begin
					ex_fire = 1'b1;
					state_d = dpq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = dpq_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			req_s1 <= req;
		end
	end

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ka_period_q   <= dpq_pkg::KEEPALIVE_RESET;
			status_code_q <= dpq_pkg::STATUS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dpq_pkg::CFG_KEEPALIVE_PERIOD: ka_period_q   <= cfg_data;
				dpq_pkg::CFG_STATUS_TYPE_CODE: status_code_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// ---------------- ring memories ----------------
	// Heads are read when the request is taken; writes land at the end of the
	// execute cycle, so no read ever overlaps a write to the same slot.
	assign wr_slot.entry_type = req_s1.entry_type;
	assign wr_slot.entry_tag  = req_s1.entry_tag;

	dpq_ring_ram #(
		.DEPTH (AUDIO_DEPTH),
		.WIDTH ($bits(dpq_pkg::slot_t))
	) u_audio_ram (
		.clk   (clk),
		.we    (a_we),
		.waddr (awp_q),
		.wdata (wr_slot),
		.re    (req_fire),
		.raddr (arp_q),
		.rdata (a_rd)
	);

	dpq_ring_ram #(
		.DEPTH (CONTROL_DEPTH),
		.WIDTH ($bits(dpq_pkg::slot_t))
	) u_ctrl_ram (
		.clk   (clk),
		.we    (c_we),
		.waddr (cwp_q),
		.wdata (wr_slot),
		.re    (req_fire),
		.raddr (crp_q),
		.rdata (c_rd)
	);

	dpq_event_counters u_counters (
		.clk    (clk),
		.arst_n (arst_n),
		.inc    (inc),
		.sel    (req_s1.counter_select),
		.value  (cnt_value)
	);

	// ---------------- execute ----------------
	assign a_wp_inc = (awp_q == A_LAST) ? '0 : awp_q + AW'(1);
	assign a_rp_inc = (arp_q == A_LAST) ? '0 : arp_q + AW'(1);
	assign c_wp_inc = (cwp_q == C_LAST) ? '0 : cwp_q + CW'(1);
	assign c_rp_inc = (crp_q == C_LAST) ? '0 : crp_q + CW'(1);
	assign a_full   = (a_wp_inc == arp_q);
	assign c_full   = (c_wp_inc == crp_q);
	assign ka_sum   = {1'b0, ka_cnt_q} + 17'd1;

	always_comb begin
		logic [AW:0] a_held;
		logic [CW:0] c_held;

		awp_n           = awp_q;
		arp_n           = arp_q;
		cwp_n           = cwp_q;
		crp_n           = crp_q;
		ka_cnt_n        = ka_cnt_q;
		inflight_kind_n = inflight_kind_q;
		inflight_slot_n = inflight_slot_q;
		inflight_type_n = inflight_type_q;
		a_we            = 1'b0;
		c_we            = 1'b0;
		inc             = '0;
		rsp_d           = '0;

		unique case (req_s1.op)
			dpq_pkg::OP_ENQ_AUDIO: begin
				a_we  = ex_fire;
				awp_n = a_wp_inc;
				if (a_full) begin
					arp_n                = a_rp_inc;
					inc.audio_over       = ex_fire;
					rsp_d.dropped_oldest = 1'b1;
				end
			end
			dpq_pkg::OP_ENQ_CTRL: begin
				c_we  = ex_fire;
				cwp_n = c_wp_inc;
				if (c_full) begin
					crp_n                = c_rp_inc;
					inc.ctrl_over        = ex_fire;
					inc.status_lost      = ex_fire && (c_rd.entry_type == status_code_q);
					rsp_d.dropped_oldest = 1'b1;
				end
				inc.status_enq = ex_fire && (req_s1.entry_type == status_code_q);
			end
			dpq_pkg::OP_TX_START: begin
				if (ka_sum >= {1'b0, ka_period_q}) begin
					ka_cnt_n            = '0;
					rsp_d.keepalive_due = 1'b1;
				end else begin
					ka_cnt_n = ka_sum[15:0];
				end
				// control ring has strict priority
				if (cwp_q != crp_q) begin
					rsp_d.sent_kind = dpq_pkg::KIND_CTRL;
					rsp_d.sent_tag  = c_rd.entry_tag;
					rsp_d.sent_type = c_rd.entry_type;
					inflight_slot_n = SLOT_W'(crp_q);
				end else if (awp_q != arp_q) begin
					rsp_d.sent_kind = dpq_pkg::KIND_AUDIO;
					rsp_d.sent_tag  = a_rd.entry_tag;
					rsp_d.sent_type = a_rd.entry_type;
					inflight_slot_n = SLOT_W'(arp_q);
				end else begin
					inflight_slot_n = '0;
				end
				inflight_kind_n = rsp_d.sent_kind;
				inflight_type_n = rsp_d.sent_type;
			end
			dpq_pkg::OP_TX_DONE: begin
				if (!req_s1.transfer_ok) begin
					inc.tx_fail = ex_fire;
				end else if (inflight_kind_q == dpq_pkg::KIND_AUDIO) begin
					// pop only if the head has not moved since the start
					if (SLOT_W'(arp_q) == inflight_slot_q && awp_q != arp_q) begin
						arp_n           = a_rp_inc;
						inc.audio_sent  = ex_fire;
						rsp_d.committed = 1'b1;
					end
				end else if (inflight_kind_q == dpq_pkg::KIND_CTRL) begin
					if (SLOT_W'(crp_q) == inflight_slot_q && cwp_q != crp_q) begin
						crp_n           = c_rp_inc;
						inc.tx_ctrl     = ex_fire;
						inc.status_sent = ex_fire && (inflight_type_q == status_code_q);
						rsp_d.committed = 1'b1;
					end
				end else begin
					inc.tx_idle = ex_fire;
				end
				inflight_kind_n = dpq_pkg::KIND_IDLE;
				inflight_slot_n = '0;
				inflight_type_n = '0;
			end
			dpq_pkg::OP_READ_CNT: begin
				rsp_d.counter_value = cnt_value;
			end
			default: ;
		endcase

		a_held = (awp_n >= arp_n) ? ({1'b0, awp_n} - {1'b0, arp_n})
		                          : ({1'b0, awp_n} + (AW+1)'(AUDIO_DEPTH) - {1'b0, arp_n});
		c_held = (cwp_n >= crp_n) ? ({1'b0, cwp_n} - {1'b0, crp_n})
		                          : ({1'b0, cwp_n} + (CW+1)'(CONTROL_DEPTH) - {1'b0, crp_n});
		rsp_d.audio_count   = 4'(a_held);
		rsp_d.control_count = 2'(c_held);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awp_q           <= '0;
			arp_q           <= '0;
			cwp_q           <= '0;
			crp_q           <= '0;
			ka_cnt_q        <= '0;
			inflight_kind_q <= dpq_pkg::KIND_IDLE;
			inflight_slot_q <= '0;
			inflight_type_q <= '0;
		end else if (ex_fire) begin
			awp_q           <= awp_n;
			arp_q           <= arp_n;
			cwp_q           <= cwp_n;
			crp_q           <= crp_n;
			ka_cnt_q        <= ka_cnt_n;
			inflight_kind_q <= inflight_kind_n;
			inflight_slot_q <= inflight_slot_n;
			inflight_type_q <= inflight_type_n;
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ex_fire) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ex_fire) begin
			rsp_q <= rsp_d;
		end
	end

	// ---------------- checks ----------------
	`DPQ_ASSERT_NEXT(a_accept_exec, clk, arst_n, req_fire, state_q == dpq_pkg::ST_EXEC)
	`DPQ_ASSERT_NEXT(a_exec_result, clk, arst_n, ex_fire, rsp_valid_q)
	`DPQ_ASSERT_SAME(a_idle_latch_clear, clk, arst_n, inflight_kind_q == dpq_pkg::KIND_IDLE, inflight_slot_q == '0 && inflight_type_q == '0)
	`DPQ_ASSERT_SAME(a_ptr_range, clk, arst_n, 1'b1, awp_q <= A_LAST && arp_q <= A_LAST && cwp_q <= C_LAST && crp_q <= C_LAST)

endmodule
